/* hw/rtl/ghash_pkg.sv */
// Shared types and constants for the GHASH accumulator.
`default_nettype none

package ghash_pkg;

    // Item operation codes
    typedef enum logic
    {
        OP_LOAD   = 1'b0,
        OP_ABSORB = 1'b1
    } op_t;

    // Register index, taken from paddr[3] (registers sit at 8-byte steps)
    typedef enum logic
    {
        REG_SUBKEY_HI = 1'b0,
        REG_SUBKEY_LO = 1'b1
    } reg_idx_t;

    localparam int unsigned BLOCK_W = 128;
    localparam int unsigned HALF_W  = 64;

    // Low terms of the field polynomial x^128 + x^7 + x^2 + x + 1
    localparam logic [7:0] GF_POLY_LOW = 8'h87;

endpackage

`default_nettype wire

/* hw/rtl/ghash_if.sv */
// Valid/ready channel interfaces for the block input and hash output.
`default_nettype none

interface ghash_block_if;
    import ghash_pkg::*;

    logic               valid;
    logic               ready;
    op_t                op;
    logic [HALF_W-1:0]  block_hi;
    logic [HALF_W-1:0]  block_lo;
    logic               last;

    modport source (output valid, output op, output block_hi, output block_lo,
                    output last, input ready);
    modport sink   (input valid, input op, input block_hi, input block_lo,
                    input last, output ready);
endinterface

interface ghash_hash_if;
    import ghash_pkg::*;

    logic               valid;
    logic               ready;
    logic [HALF_W-1:0]  hash_hi;
    logic [HALF_W-1:0]  hash_lo;
    logic               final_res;

    modport source (output valid, output hash_hi, output hash_lo, output final_res,
                    input ready);
    modport sink   (input valid, input hash_hi, input hash_lo, input final_res,
                    output ready);
endinterface

`default_nettype wire

/* hw/rtl/ghash_accumulator.sv */
// GHASH accumulator top level: input register, GF(2^128) multiply, hash register.
//
// Usage:
//   block_ch carries one beat per 128-bit block: op LOAD replaces the running
//   hash with the block, op ABSORB XORs the block into the hash and multiplies
//   by the subkey H. last is echoed as final_res on the matching result.
//   hash_ch returns exactly one beat per block: the running hash after it.
//   H is written over the APB port (subkey_hi at 0x0, subkey_lo at 0x8); the user
//   must write it only while no block is in flight; the block does not enforce this.
//   pready is tied high.
// Datapath:
//   An accepted beat is held in the input register; the full carry-less multiply
//   and reduction run combinationally from there into the hash register, which
//   offers the result. One beat per cycle is sustained while hash_ch is not held
//   off; the running hash feeds back from the hash register into the next multiply.
// Reset: rst_n clears the subkey, the running hash and both valid flags.
// Stall: while hash_ch is held off, one more beat is taken into the input
//   register, then block_ch.ready drops until the result beat moves.
`default_nettype none

module ghash_accumulator (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [3:0]           paddr,
    input  wire logic [63:0]          pwdata,
    output      logic [63:0]          prdata,
    output      logic                 pready,
    // channels
    ghash_block_if.sink               block_ch,
    ghash_hash_if.source              hash_ch
);
    import ghash_pkg::*;

    // GF(2^128) product in the reflected GCM bit order
    function automatic logic [BLOCK_W-1:0] gf128_mul(input logic [BLOCK_W-1:0] x,
                                                      input logic [BLOCK_W-1:0] y);
        logic [BLOCK_W-1:0]   a;
        logic [BLOCK_W-1:0]   b;
        logic [2*BLOCK_W-2:0] c;
        logic [BLOCK_W-2:0]   d;
        logic [BLOCK_W+5:0]   t;
        logic [5:0]           e;
        logic [BLOCK_W-1:0]   low;
        logic [BLOCK_W-1:0]   z;
        // bit 127 of the word is the x^0 coefficient
        for (int i = 0; i < BLOCK_W; i++)
        begin
            a[i] = x[BLOCK_W-1-i];
            b[i] = y[BLOCK_W-1-i];
        end
        // carry-less product, each bit an independent AND-XOR tree
        c = '0;
        for (int k = 0; k < 2*BLOCK_W-1; k++)
        begin
            for (int i = 0; i < BLOCK_W; i++)
            begin
                if ((k - i >= 0) && (k - i < BLOCK_W))
                begin
                    c[k] = c[k] ^ (a[i] & b[k-i]);
                end
            end
        end
        // fold the upper half: x^128 == x^7 + x^2 + x + 1
        d = c[2*BLOCK_W-2:BLOCK_W];
        t = '0;
        for (int j = 0; j < 8; j++)
        begin
            if (GF_POLY_LOW[j])
            begin
                t = t ^ ({7'b0, d} << j);
            end
        end
        low = c[BLOCK_W-1:0] ^ t[BLOCK_W-1:0];
        // second fold of the few overflow bits, no further carry out
        e = t[BLOCK_W+5:BLOCK_W];
        for (int j = 0; j < 8; j++)
        begin
            if (GF_POLY_LOW[j])
            begin
                low = low ^ ({122'b0, e} << j);
            end
        end
        for (int i = 0; i < BLOCK_W; i++)
        begin
            z[BLOCK_W-1-i] = low[i];
        end
        return z;
    endfunction

    logic [HALF_W-1:0]  subkey_hi_reg;
    logic [HALF_W-1:0]  subkey_lo_reg;
    logic [HALF_W-1:0]  hash_hi_reg;
    logic [HALF_W-1:0]  hash_lo_reg;
    logic               final_reg;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic               in_valid_reg;
    logic               in_valid_next;
    op_t                in_op_reg;
    logic [HALF_W-1:0]  in_hi_reg;
    logic [HALF_W-1:0]  in_lo_reg;
    logic               in_last_reg;

    logic               advance;
    logic               cfg_write;
    logic [BLOCK_W-1:0] product;
    logic [BLOCK_W-1:0] hash_next;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subkey_hi_reg <= '0;
            subkey_lo_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(paddr[3]))
                REG_SUBKEY_HI: subkey_hi_reg <= pwdata;
                REG_SUBKEY_LO: subkey_lo_reg <= pwdata;
                default:       subkey_hi_reg <= subkey_hi_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[3]))
            REG_SUBKEY_HI: prdata = subkey_hi_reg;
            REG_SUBKEY_LO: prdata = subkey_lo_reg;
            default:       prdata = '0;
        endcase
    end

    // handshake: the input stage moves whenever the result slot is free or draining
    assign advance        = in_valid_reg && (!out_valid_reg || hash_ch.ready);
    assign block_ch.ready = !in_valid_reg || advance;
    assign in_valid_next  = block_ch.ready ? block_ch.valid : in_valid_reg;
    assign out_valid_next = advance ? 1'b1 : (out_valid_reg && !hash_ch.ready);

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (block_ch.valid && block_ch.ready)
        begin
            in_op_reg   <= block_ch.op;
            in_hi_reg   <= block_ch.block_hi;
            in_lo_reg   <= block_ch.block_lo;
            in_last_reg <= block_ch.last;
        end
    end

    // next running hash
    assign product = gf128_mul({hash_hi_reg, hash_lo_reg} ^ {in_hi_reg, in_lo_reg},
                               {subkey_hi_reg, subkey_lo_reg});

    always_comb
    begin
        unique case (in_op_reg)
            OP_LOAD:   hash_next = {in_hi_reg, in_lo_reg};
            OP_ABSORB: hash_next = product;
            default:   hash_next = product;
        endcase
    end

    // hash register doubles as the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_hi_reg   <= '0;
            hash_lo_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                hash_hi_reg <= hash_next[BLOCK_W-1:HALF_W];
                hash_lo_reg <= hash_next[HALF_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            final_reg <= in_last_reg;
        end
    end

    assign hash_ch.valid     = out_valid_reg;
    assign hash_ch.hash_hi   = hash_hi_reg;
    assign hash_ch.hash_lo   = hash_lo_reg;
    assign hash_ch.final_res = final_reg;

    // running hash only changes when an item moves to the output
    a_hash_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(hash_hi_reg) && $stable(hash_lo_reg))
        else $error("running hash changed without an item");

    // every item that moves leaves a result beat
    a_result_made: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("item moved but no result offered");

    // a held input item is neither lost nor altered
    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_hi_reg)
                                     && $stable(in_lo_reg))
        else $error("stalled input item lost");

    // load takes the block verbatim
    a_load_copy: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_op_reg == OP_LOAD) |=>
            (hash_hi_reg == $past(in_hi_reg)) && (hash_lo_reg == $past(in_lo_reg)))
        else $error("load did not copy block");

    // zero subkey gives zero hash on absorb
    a_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_op_reg == OP_ABSORB) && (subkey_hi_reg == '0)
            && (subkey_lo_reg == '0) |=> (hash_hi_reg == '0) && (hash_lo_reg == '0))
        else $error("absorb with zero subkey gave nonzero hash");

endmodule

`default_nettype wire

/* test/ghash_accumulator_tb.sv */
// Testbench for the GHASH accumulator: directed and random block streams checked against a GF(2^128) model.
`timescale 1ns / 100ps

module ghash_accumulator_tb;
    import ghash_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned DRAIN_CYCLES  = 4;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_ITEMS   = 200;
    localparam int unsigned PRINT_LIMIT   = 50;

    localparam logic [HALF_W-1:0] ALL_ONES = '1;
    localparam logic [HALF_W-1:0] TOP_BIT  = {1'b1, {(HALF_W-1){1'b0}}};
    // x^1 in the reflected bit order: second bit from the top of byte 0
    localparam logic [HALF_W-1:0] X_POWER1 = {2'b01, {(HALF_W-2){1'b0}}};

    typedef struct {
        op_t               op;
        logic [HALF_W-1:0] block_hi;
        logic [HALF_W-1:0] block_lo;
        logic              last;
    } block_beat_t;

    typedef struct {
        logic [HALF_W-1:0] hash_hi;
        logic [HALF_W-1:0] hash_lo;
        logic              final_res;
    } hash_beat_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    ghash_block_if block_ch ();
    ghash_hash_if  hash_ch ();

    ghash_accumulator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .block_ch (block_ch),
        .hash_ch  (hash_ch)
    );

    // Model state: subkey shadow and running hash
    logic [HALF_W-1:0] key_hi = '0;
    logic [HALF_W-1:0] key_lo = '0;
    logic [HALF_W-1:0] run_hi = '0;
    logic [HALF_W-1:0] run_lo = '0;

    block_beat_t block_queue[$];
    hash_beat_t  hash_expect[$];
    block_beat_t in_flight;
    int unsigned send_gap      = 0;
    int unsigned recv_stall    = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count   = 0;
    logic        steady        = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Carry-less multiply with reduction, bit 127 is the x^0 coefficient
    function automatic logic [BLOCK_W-1:0] gf_mul(logic [BLOCK_W-1:0] x,
                                                  logic [BLOCK_W-1:0] y);
        logic [BLOCK_W-1:0] acc;
        logic [BLOCK_W-1:0] v;
        logic               carry;
        acc = '0;
        v   = y;
        for (int i = 0; i < BLOCK_W; i++)
        begin
            if (x[BLOCK_W-1-i])
                acc ^= v;
            carry = v[0];
            v     = v >> 1;
            // 0xE1 is the low polynomial terms 0x87 bit-reversed
            if (carry)
                v[BLOCK_W-1 -: 8] ^= 8'hE1;
        end
        return acc;
    endfunction

    // Advance the running hash by one beat and return the expected result
    function automatic hash_beat_t predict_hash(block_beat_t b);
        hash_beat_t         r;
        logic [BLOCK_W-1:0] y;
        if (b.op == OP_LOAD)
            y = {b.block_hi, b.block_lo};
        else
            y = gf_mul({run_hi, run_lo} ^ {b.block_hi, b.block_lo}, {key_hi, key_lo});
        {run_hi, run_lo} = y;
        r.hash_hi   = run_hi;
        r.hash_lo   = run_lo;
        r.final_res = b.last;
        return r;
    endfunction

    // Idle length: mostly none or short, a few long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (steady)
            return 0;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [HALF_W-1:0] rand_half();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 6)
            return '0;
        if (roll < 12)
            return ALL_ONES;
        if (roll < 17)
            return TOP_BIT >> $urandom_range(HALF_W-1);
        return {$urandom, $urandom};
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic add_beat(op_t op, logic [HALF_W-1:0] hi, logic [HALF_W-1:0] lo,
                            logic last);
        block_beat_t b;
        b.op       = op;
        b.block_hi = hi;
        b.block_lo = lo;
        b.last     = last;
        block_queue.push_back(b);
    endtask

    // Wait until every queued beat is sent and every result is back;
    // checked at the falling edge, once all edge updates have settled
    task automatic drain();
        while (block_queue.size() != 0 || block_ch.valid || hash_expect.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(reg_idx_t idx, logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(reg_idx_t idx, output logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 3'b000};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Load H, update the shadow, and read both halves back
    task automatic set_subkey(logic [HALF_W-1:0] hi, logic [HALF_W-1:0] lo);
        logic [63:0] readback;
        apb_write(REG_SUBKEY_HI, hi);
        apb_write(REG_SUBKEY_LO, lo);
        key_hi = hi;
        key_lo = lo;
        apb_read(REG_SUBKEY_HI, readback);
        if (readback !== hi)
            report_mismatch($sformatf("subkey_hi read %h, wrote %h", readback, hi));
        apb_read(REG_SUBKEY_LO, readback);
        if (readback !== lo)
            report_mismatch($sformatf("subkey_lo read %h, wrote %h", readback, lo));
    endtask

    // Block driver: predicts on each accepted beat, then offers the next
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (block_ch.valid && block_ch.ready)
                hash_expect.push_back(predict_hash(in_flight));
            if (!block_ch.valid || block_ch.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    block_ch.valid <= 1'b0;
                end
                else if (block_queue.size() != 0)
                begin
                    in_flight = block_queue.pop_front();
                    block_ch.valid    <= 1'b1;
                    block_ch.op       <= in_flight.op;
                    block_ch.block_hi <= in_flight.block_hi;
                    block_ch.block_lo <= in_flight.block_lo;
                    block_ch.last     <= in_flight.last;
                    send_gap = pick_gap();
                end
                else
                begin
                    block_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Hash monitor: checks each result beat and stalls at random
    always @(posedge clk)
    begin
        hash_beat_t want;
        if (rst_n)
        begin
            if (hash_ch.valid && hash_ch.ready)
            begin
                if (hash_expect.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected hash beat %h_%h",
                                              hash_ch.hash_hi, hash_ch.hash_lo));
                end
                else
                begin
                    want = hash_expect.pop_front();
                    if (hash_ch.hash_hi !== want.hash_hi)
                        report_mismatch($sformatf("hash_hi %h, expected %h",
                                                  hash_ch.hash_hi, want.hash_hi));
                    if (hash_ch.hash_lo !== want.hash_lo)
                        report_mismatch($sformatf("hash_lo %h, expected %h",
                                                  hash_ch.hash_lo, want.hash_lo));
                    if (hash_ch.final_res !== want.final_res)
                        report_mismatch($sformatf("final_res %b, expected %b",
                                                  hash_ch.final_res, want.final_res));
                end
            end
            if (recv_stall != 0)
            begin
                recv_stall--;
                hash_ch.ready <= 1'b0;
            end
            else
            begin
                hash_ch.ready <= 1'b1;
                recv_stall = pick_gap();
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus sequence
    initial
    begin
        logic [HALF_W-1:0] h_hi;
        logic [HALF_W-1:0] h_lo;
        int unsigned       made;
        int unsigned       run_len;

        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        block_ch.valid    = 1'b0;
        block_ch.op       = OP_LOAD;
        block_ch.block_hi = '0;
        block_ch.block_lo = '0;
        block_ch.last     = 1'b0;
        hash_ch.ready     = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Zero subkey after reset: every absorb collapses to zero
        add_beat(OP_ABSORB, ALL_ONES, ALL_ONES, 1'b0);
        add_beat(OP_LOAD, ALL_ONES, ALL_ONES, 1'b1);
        add_beat(OP_ABSORB, '0, '0, 1'b1);
        add_beat(OP_LOAD, TOP_BIT, 64'h1, 1'b0);
        drain();

        // H = 1: absorb is a plain XOR into the hash
        set_subkey(TOP_BIT, '0);
        add_beat(OP_ABSORB, TOP_BIT, '0, 1'b0);
        add_beat(OP_ABSORB, '0, 64'h1, 1'b0);
        add_beat(OP_ABSORB, ALL_ONES, ALL_ONES, 1'b1);
        add_beat(OP_LOAD, '0, '0, 1'b0);
        drain();

        // H = x: the x^127 coefficient shifts out and folds back through the polynomial
        set_subkey(X_POWER1, '0);
        add_beat(OP_LOAD, '0, 64'h1, 1'b0);
        add_beat(OP_ABSORB, '0, '0, 1'b0);
        add_beat(OP_ABSORB, ALL_ONES, '0, 1'b1);
        add_beat(OP_ABSORB, '0, ALL_ONES, 1'b0);
        drain();

        // All-ones subkey
        set_subkey(ALL_ONES, ALL_ONES);
        add_beat(OP_LOAD, ALL_ONES, '0, 1'b0);
        add_beat(OP_ABSORB, '0, '0, 1'b0);
        add_beat(OP_ABSORB, ALL_ONES, ALL_ONES, 1'b0);
        add_beat(OP_ABSORB, '0, 64'h1, 1'b1);
        add_beat(OP_LOAD, ALL_ONES, ALL_ONES, 1'b1);
        add_beat(OP_ABSORB, TOP_BIT, TOP_BIT, 1'b1);
        drain();

        // Random phases, each with its own subkey; the sender drains between them
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 3)
            begin
                h_hi = '0;
                h_lo = '0;
            end
            else if (p == 5)
            begin
                h_hi = ALL_ONES;
                h_lo = ALL_ONES;
            end
            else
            begin
                h_hi = rand_half();
                h_lo = rand_half();
            end
            steady = (p == 2 || p == 6);
            set_subkey(h_hi, h_lo);
            made = 0;
            while (made < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 10)
                begin
                    // stray beat with random fields
                    add_beat($urandom_range(1) ? OP_ABSORB : OP_LOAD,
                             rand_half(), rand_half(), 1'($urandom_range(1)));
                    made++;
                end
                else
                begin
                    // message: optional resume from a saved hash, then blocks
                    if ($urandom_range(1))
                    begin
                        add_beat(OP_LOAD, rand_half(), rand_half(), 1'b0);
                        made++;
                    end
                    run_len = $urandom_range(12, 1);
                    for (int k = 0; k < run_len; k++)
                        add_beat(OP_ABSORB, rand_half(), rand_half(), 1'(k == run_len - 1));
                    made += run_len;
                end
            end
            drain();
        end

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
